@@ design/gdc_pkg.sv @@
// shared types, constants and tables of the gregorian day number converter
`timescale 1ns / 1ps
package gdc_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int MDAY_W  = 5;
  localparam int COUNT_W = 22;
  localparam int YDAY_W  = 9;

  localparam logic [14:0] YEAR_SHIFT    = 15'd400;
  localparam logic [22:0] EPOCH_SHIFTED = 23'd146037;
  localparam logic [22:0] COUNT_BIAS    = 23'd146038;
  localparam logic [22:0] DAYS_PER_YEAR = 23'd365;

  localparam logic [35:0] YEAR_SCALE = 36'd10000;
  localparam logic [35:0] YEAR_BIAS  = 36'd14780;
  localparam logic [35:0] CYCLE_DAYS = 36'd3652425;
  // floor(2^32 * 10000 / 3652425)
  localparam logic [23:0] YEAR_RECIP = 24'((64'd10000 << 32) / 64'd3652425);

  // x / 100 as (x * 5243) >> 19, exact below 43690
  localparam logic [27:0] DIV100_RECIP = 28'd5243;

  // (100 * ddd + 52) / 3060 as ((25 * ddd + 13) * 87725) >> 26
  localparam logic [13:0] MDAY_SCALE  = 14'd25;
  localparam logic [13:0] MDAY_BIAS   = 14'd13;
  localparam logic [30:0] MONTH_RECIP = 31'd87725;

  localparam logic [3:0] JAN_INDEX = 4'd10;
  localparam logic [9:0] JAN_START = 10'd306;

  // (month + 9) % 12 for every 4-bit month code
  localparam logic [3:0] MONTH_INDEX [16] = '{
    4'd9, 4'd10, 4'd11, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4,
    4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd0
  };

  // (index * 306 + 5) / 10, days from 1 march to the month start
  localparam logic [8:0] MONTH_OFFSET [16] = '{
    9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153, 9'd184, 9'd214,
    9'd245, 9'd275, 9'd306, 9'd337, 9'd367, 9'd398, 9'd428, 9'd459
  };

  typedef struct packed {
    logic                 func;
    logic [YEAR_W-1:0]    year_in;
    logic [MONTH_W-1:0]   month_in;
    logic [MDAY_W-1:0]    mday_in;
    logic [COUNT_W-1:0]   count_in;
  } query_t;

  typedef struct packed {
    logic        func;
    logic [22:0] dn;
    logic [14:0] yr;
    logic [9:0]  off;
  } est_t;

  typedef struct packed {
    logic             func;
    logic [22:0]      dn;
    logic [14:0]      yr;
    logic [9:0]       off;
    logic [2:0][22:0] days;
  } leap_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count_out;
    logic [YEAR_W-1:0]  year_out;
    logic [MONTH_W-1:0] month_out;
    logic [MDAY_W-1:0]  mday_out;
    logic [YDAY_W-1:0]  yday_out;
  } result_t;

  function automatic logic [7:0] div100(input logic [14:0] y);
    logic [27:0] p;
    p = 28'(y) * DIV100_RECIP;
    return p[26:19];
  endfunction

endpackage

@@ design/gdc_if.sv @@
// query and answer channel interfaces
`timescale 1ns / 1ps
interface gdc_query_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [gdc_pkg::YEAR_W-1:0]    year_in;
  logic [gdc_pkg::MONTH_W-1:0]   month_in;
  logic [gdc_pkg::MDAY_W-1:0]    mday_in;
  logic [gdc_pkg::COUNT_W-1:0]   count_in;

  modport source (output valid, func, year_in, month_in, mday_in, count_in, input ready);
  modport sink (input valid, func, year_in, month_in, mday_in, count_in, output ready);
endinterface

interface gdc_answer_if;
  logic                          valid;
  logic                          ready;
  logic [gdc_pkg::COUNT_W-1:0]   count_out;
  logic [gdc_pkg::YEAR_W-1:0]    year_out;
  logic [gdc_pkg::MONTH_W-1:0]   month_out;
  logic [gdc_pkg::MDAY_W-1:0]    mday_out;
  logic [gdc_pkg::YDAY_W-1:0]    yday_out;

  modport source (output valid, count_out, year_out, month_out, mday_out, yday_out,
                  input ready);
  modport sink (input valid, count_out, year_out, month_out, mday_out, yday_out,
                output ready);
endinterface

@@ design/gregorian_day_number_converter.sv @@
// top level of the gregorian date and day count converter
//
//   channel  role    payload
//   query    sink    func, year_in, month_in, mday_in, count_in
//   answer   source  count_out, year_out, month_out, mday_out, yday_out
//
// eight register stages, one item per cycle while the answer side keeps taking them
// the stage depth is set by the year estimate multiplies and the leap day sums
// each stage holds its item while the one after it is full and stalled, so bubbles close up
// rst clears the valid bits only
`timescale 1ns / 1ps
module gregorian_day_number_converter (
  input  logic                clk,
  input  logic                rst,
  gdc_query_if.sink           query,
  gdc_answer_if.source        answer
);

  gdc_pkg::query_t  q;
  gdc_pkg::est_t    est;
  gdc_pkg::leap_t   leap;
  gdc_pkg::result_t result;
  logic             est_valid, est_ready;
  logic             leap_valid, leap_ready;

  always_comb begin
    q.func     = query.func;
    q.year_in  = query.year_in;
    q.month_in = query.month_in;
    q.mday_in  = query.mday_in;
    q.count_in = query.count_in;
  end

  gdc_year_est u_year_est (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (query.valid),
    .up_ready   (query.ready),
    .query      (q),
    .down_valid (est_valid),
    .down_ready (est_ready),
    .est        (est)
  );

  gdc_leap u_leap (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (est_valid),
    .up_ready   (est_ready),
    .est        (est),
    .down_valid (leap_valid),
    .down_ready (leap_ready),
    .leap       (leap)
  );

  gdc_date u_date (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (leap_valid),
    .up_ready   (leap_ready),
    .leap       (leap),
    .down_valid (answer.valid),
    .down_ready (answer.ready),
    .result     (result)
  );

  assign answer.count_out = result.count_out;
  assign answer.year_out  = result.year_out;
  assign answer.month_out = result.month_out;
  assign answer.mday_out  = result.mday_out;
  assign answer.yday_out  = result.yday_out;

  a_reset_empty: assert property (@(posedge clk) rst |=> !answer.valid)
    else $error("answer valid right after reset");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !query.ready |-> (answer.valid && !answer.ready))
    else $error("query held off while the answer side is free");

  a_field_split: assert property (@(posedge clk) disable iff (rst)
    (answer.valid && answer.count_out != '0) |->
      (answer.month_out == '0 && answer.mday_out == '0 && answer.yday_out == '0))
    else $error("count and date fields both set");

endmodule

@@ design/gdc_year_est.sv @@
// stages one to three: day number, year estimate by reciprocal and its correction, or shifted year and day offset
`timescale 1ns / 1ps
module gdc_year_est (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  output logic            up_ready,
  input  gdc_pkg::query_t query,
  output logic            down_valid,
  input  logic            down_ready,
  output gdc_pkg::est_t   est
);

  typedef struct packed {
    gdc_pkg::est_t base;
    logic [35:0]   num;
    logic [35:0]   prod;
  } mul_t;

  logic          v1, v2, v3;
  logic          en1, en2, en3;
  gdc_pkg::est_t s1, s1_next, s3, s3_next;
  mul_t          s2, s2_next;

  logic [22:0] dn;
  logic [46:0] est_prod;
  logic [3:0]  mi;
  logic [14:0] yy;
  logic        bump;

  assign en3      = !v3 || down_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign up_ready = en1;

  always_comb begin
    dn            = 23'(query.count_in) + gdc_pkg::EPOCH_SHIFTED;
    est_prod      = 47'(dn) * 47'(gdc_pkg::YEAR_RECIP);
    mi            = gdc_pkg::MONTH_INDEX[query.month_in];
    yy            = 15'(query.year_in) + gdc_pkg::YEAR_SHIFT - 15'(mi >= gdc_pkg::JAN_INDEX);
    s1_next.func  = query.func;
    s1_next.dn    = dn;
    s1_next.yr    = query.func ? est_prod[46:32] : yy;
    s1_next.off   = 10'(gdc_pkg::MONTH_OFFSET[mi]) + 10'(query.mday_in);
  end

  always_comb begin
    s2_next.base = s1;
    s2_next.num  = 36'(s1.dn) * gdc_pkg::YEAR_SCALE + gdc_pkg::YEAR_BIAS;
    s2_next.prod = 36'(s1.yr) * gdc_pkg::CYCLE_DAYS;
  end

  always_comb begin
    bump       = s2.base.func && (s2.num >= s2.prod + gdc_pkg::CYCLE_DAYS);
    s3_next    = s2.base;
    s3_next.yr = s2.base.yr + 15'(bump);
  end

  always_ff @(posedge clk) begin
    if (en1) s1 <= s1_next;
    if (en2) s2 <= s2_next;
    if (en3) s3 <= s3_next;
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= up_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  assign down_valid = v3;
  assign est        = s3;

endmodule

@@ design/gdc_leap.sv @@
// stages four and five: days before the march-based year for y, y-1 and y-2
`timescale 1ns / 1ps
module gdc_leap (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  output logic           up_ready,
  input  gdc_pkg::est_t  est,
  output logic           down_valid,
  input  logic           down_ready,
  output gdc_pkg::leap_t leap
);

  typedef struct packed {
    gdc_pkg::est_t    base;
    logic [2:0][7:0]  q;
    logic [2:0][22:0] lin;
  } part_t;

  logic           v4, v5;
  logic           en4, en5;
  part_t          s4, s4_next;
  gdc_pkg::leap_t s5, s5_next;

  logic [2:0][14:0] yk;

  assign en5      = !v5 || down_ready;
  assign en4      = !v4 || en5;
  assign up_ready = en4;

  always_comb begin
    s4_next.base = est;
    for (int k = 0; k < 3; k++) begin
      yk[k]          = est.yr - 15'(k);
      s4_next.q[k]   = gdc_pkg::div100(yk[k]);
      s4_next.lin[k] = 23'(yk[k]) * gdc_pkg::DAYS_PER_YEAR + 23'(yk[k] >> 2);
    end
  end

  always_comb begin
    s5_next.func = s4.base.func;
    s5_next.dn   = s4.base.dn;
    s5_next.yr   = s4.base.yr;
    s5_next.off  = s4.base.off;
    for (int k = 0; k < 3; k++) begin
      s5_next.days[k] = s4.lin[k] - 23'(s4.q[k]) + 23'(s4.q[k] >> 2);
    end
  end

  always_ff @(posedge clk) begin
    if (en4) s4 <= s4_next;
    if (en5) s5 <= s5_next;
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en4) v4 <= up_valid;
      if (en5) v5 <= v4;
    end
  end

  assign down_valid = v5;
  assign leap       = s5;

endmodule

@@ design/gdc_date.sv @@
// stages six to eight: day of year, month split and result assembly
`timescale 1ns / 1ps
module gdc_date (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  gdc_pkg::leap_t   leap,
  output logic             down_valid,
  input  logic             down_ready,
  output gdc_pkg::result_t result
);

  typedef struct packed {
    logic        func;
    logic [8:0]  ddd;
    logic [14:0] yc;
    logic [8:0]  plen;
    logic [21:0] cnt;
  } day_t;

  typedef struct packed {
    day_t       base;
    logic [3:0] mi;
  } mon_t;

  logic             v6, v7, v8;
  logic             en6, en7, en8;
  day_t             s6, s6_next;
  mon_t             s7, s7_next;
  gdc_pkg::result_t s8, s8_next;

  logic [23:0] d0, d1;
  logic        neg;
  logic [22:0] len0, len1, cnt_full;
  logic [13:0] x;
  logic [30:0] mprod;
  logic        janfeb;
  logic [14:0] yf, yr_rel;
  logic [9:0]  yday_full, dd_full;
  logic [3:0]  mo;

  assign en8      = !v8 || down_ready;
  assign en7      = !v7 || en8;
  assign en6      = !v6 || en7;
  assign up_ready = en6;

  always_comb begin
    d0           = 24'(leap.dn) - 24'(leap.days[0]);
    d1           = 24'(leap.dn) - 24'(leap.days[1]);
    neg          = d0[23];
    len0         = leap.days[0] - leap.days[1];
    len1         = leap.days[1] - leap.days[2];
    cnt_full     = leap.days[0] + 23'(leap.off) - gdc_pkg::COUNT_BIAS;
    s6_next.func = leap.func;
    s6_next.ddd  = neg ? d1[8:0] : d0[8:0];
    s6_next.yc   = leap.yr - 15'(neg);
    s6_next.plen = neg ? len1[8:0] : len0[8:0];
    s6_next.cnt  = cnt_full[21:0];
  end

  always_comb begin
    x            = 14'(s6.ddd) * gdc_pkg::MDAY_SCALE + gdc_pkg::MDAY_BIAS;
    mprod        = 31'(x) * gdc_pkg::MONTH_RECIP;
    s7_next.base = s6;
    s7_next.mi   = mprod[29:26];
  end

  always_comb begin
    janfeb = s7.mi >= gdc_pkg::JAN_INDEX;
    mo     = janfeb ? s7.mi - 4'd9 : s7.mi + 4'd3;
    yf     = s7.base.yc + 15'(janfeb);
    yr_rel = yf - gdc_pkg::YEAR_SHIFT;
    yday_full = janfeb ? 10'(s7.base.ddd) - gdc_pkg::JAN_START
                       : 10'(s7.base.ddd) + 10'(s7.base.plen) - gdc_pkg::JAN_START;
    dd_full = 10'(s7.base.ddd) - 10'(gdc_pkg::MONTH_OFFSET[s7.mi]) + 10'd1;
    if (s7.base.func) begin
      s8_next.count_out = '0;
      s8_next.year_out  = yr_rel[13:0];
      s8_next.month_out = mo;
      s8_next.mday_out  = dd_full[4:0];
      s8_next.yday_out  = yday_full[8:0];
    end else begin
      s8_next.count_out = s7.base.cnt;
      s8_next.year_out  = '0;
      s8_next.month_out = '0;
      s8_next.mday_out  = '0;
      s8_next.yday_out  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en6) s6 <= s6_next;
    if (en7) s7 <= s7_next;
    if (en8) s8 <= s8_next;
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else begin
      if (en6) v6 <= up_valid;
      if (en7) v7 <= v6;
      if (en8) v8 <= v7;
    end
  end

  assign down_valid = v8;
  assign result     = s8;

endmodule

@@ sim/gregorian_day_number_converter_tb.sv @@
// testbench of the gregorian day number converter against a predictor
`timescale 1ns / 1ps
module gregorian_day_number_converter_tb;

  localparam logic FUNC_DATE_TO_COUNT = 1'b0;
  localparam logic FUNC_COUNT_TO_DATE = 1'b1;

  localparam longint YEARS_OFFSET = 400;
  localparam longint EPOCH_DAY    = 146037;
  localparam int unsigned COUNT_MAX = 3652424;
  localparam int unsigned YEAR_MAX  = 9999;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 24;
  localparam int MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst;

  gdc_query_if  query_ch ();
  gdc_answer_if answer_ch ();

  gregorian_day_number_converter u_top (
    .clk    (clk),
    .rst    (rst),
    .query  (query_ch),
    .answer (answer_ch)
  );

  always #1 clk = ~clk;

  gdc_pkg::result_t answers_due[$];
  int      mismatches  = 0;
  int      cycle_count = 0;
  bit      idle_en     = 1'b0;
  int      hold_request = 0;

  // day arithmetic on the march-based year

  function automatic longint days_to_year(longint y);
    return 365 * y + y / 4 - y / 100 + y / 400;
  endfunction

  function automatic longint march_day(longint y, longint m, longint d);
    longint mi;
    mi = (m + 9) % 12;
    return days_to_year(y - mi / 10) + (mi * 306 + 5) / 10 + d - 1;
  endfunction

  function automatic gdc_pkg::result_t convert_date(gdc_pkg::query_t q);
    gdc_pkg::result_t r;
    longint  dn;
    longint  yr;
    longint  ddd;
    longint  mi;
    r = '0;
    if (q.func == FUNC_DATE_TO_COUNT) begin
      r.count_out = gdc_pkg::COUNT_W'(
          march_day(longint'(q.year_in) + YEARS_OFFSET, longint'(q.month_in),
                    longint'(q.mday_in)) - EPOCH_DAY);
    end else begin
      dn  = longint'(q.count_in) + EPOCH_DAY;
      yr  = (10000 * dn + 14780) / 3652425;
      ddd = dn - days_to_year(yr);
      if (ddd < 0) begin
        yr--;
        ddd = dn - days_to_year(yr);
      end
      mi = (100 * ddd + 52) / 3060;
      yr = yr + (mi + 2) / 12;
      r.year_out  = gdc_pkg::YEAR_W'(yr - YEARS_OFFSET);
      r.month_out = gdc_pkg::MONTH_W'((mi + 2) % 12 + 1);
      r.mday_out  = gdc_pkg::MDAY_W'(ddd - (mi * 306 + 5) / 10 + 1);
      r.yday_out  = gdc_pkg::YDAY_W'(dn - march_day(yr, 1, 1));
    end
    return r;
  endfunction

  // stimulus builders

  function automatic int unsigned month_length(int unsigned y, int unsigned m);
    if (m == 2) begin
      return (y % 4 == 0 && (y % 100 != 0 || y % 400 == 0)) ? 29 : 28;
    end
    if (m == 4 || m == 6 || m == 9 || m == 11) begin
      return 30;
    end
    return 31;
  endfunction

  function automatic gdc_pkg::query_t noise_query();
    return gdc_pkg::query_t'($bits(gdc_pkg::query_t)'({$urandom(), $urandom()}));
  endfunction

  function automatic gdc_pkg::query_t date_query(int unsigned y, int unsigned m,
                                                 int unsigned d);
    gdc_pkg::query_t q;
    q          = noise_query();
    q.func     = FUNC_DATE_TO_COUNT;
    q.year_in  = gdc_pkg::YEAR_W'(y);
    q.month_in = gdc_pkg::MONTH_W'(m);
    q.mday_in  = gdc_pkg::MDAY_W'(d);
    return q;
  endfunction

  function automatic gdc_pkg::query_t count_query(int unsigned c);
    gdc_pkg::query_t q;
    q          = noise_query();
    q.func     = FUNC_COUNT_TO_DATE;
    q.count_in = gdc_pkg::COUNT_W'(c);
    return q;
  endfunction

  function automatic gdc_pkg::query_t random_query();
    int unsigned      pick;
    int unsigned      y;
    int unsigned      m;
    gdc_pkg::result_t r;
    pick = $urandom_range(0, 99);
    y    = $urandom_range(0, YEAR_MAX);
    m    = $urandom_range(1, 12);
    if (pick < 45) begin
      return date_query(y, m, $urandom_range(1, month_length(y, m)));
    end else if (pick < 70) begin
      return count_query($urandom_range(0, COUNT_MAX));
    end else if (pick < 85) begin
      // counts next to a month start, where year and month roll over
      r = convert_date(date_query(y, m, 1));
      return count_query(32'(r.count_out) + $urandom_range(0, 2) - 1);
    end
    return noise_query();
  endfunction

  // query driver

  task automatic send_query(input gdc_pkg::query_t q);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      query_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    query_ch.valid    <= 1'b1;
    query_ch.func     <= q.func;
    query_ch.year_in  <= q.year_in;
    query_ch.month_in <= q.month_in;
    query_ch.mday_in  <= q.mday_in;
    query_ch.count_in <= q.count_in;
    @(posedge clk);
    while (!query_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    query_ch.valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
  endtask

  // answer side: random idling and the long hold-off

  initial begin
    answer_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        answer_ch.ready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        answer_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        answer_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // scoreboard

  task automatic note_mismatch(input string what, input longint want, input longint got);
    if (mismatches < MAX_REPORTS) begin
      $display("mismatch on %s at cycle %0d: expected %0d, got %0d",
               what, cycle_count, want, got);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin : score
    gdc_pkg::result_t want;
    gdc_pkg::result_t got;
    got = {answer_ch.count_out, answer_ch.year_out, answer_ch.month_out,
           answer_ch.mday_out, answer_ch.yday_out};
    if (!rst && answer_ch.valid && answer_ch.ready) begin
      if (answers_due.size() == 0) begin
        if (mismatches < MAX_REPORTS) begin
          $display("unexpected answer transfer at cycle %0d", cycle_count);
        end
        mismatches++;
      end else begin
        want = answers_due.pop_front();
        if (got.count_out !== want.count_out) begin
          note_mismatch("count_out", longint'(want.count_out), longint'(got.count_out));
        end
        if (got.year_out !== want.year_out) begin
          note_mismatch("year_out", longint'(want.year_out), longint'(got.year_out));
        end
        if (got.month_out !== want.month_out) begin
          note_mismatch("month_out", longint'(want.month_out), longint'(got.month_out));
        end
        if (got.mday_out !== want.mday_out) begin
          note_mismatch("mday_out", longint'(want.mday_out), longint'(got.mday_out));
        end
        if (got.yday_out !== want.yday_out) begin
          note_mismatch("yday_out", longint'(want.yday_out), longint'(got.yday_out));
        end
      end
    end
    if (!rst && query_ch.valid && query_ch.ready) begin
      answers_due.push_back(convert_date({query_ch.func, query_ch.year_in,
                                          query_ch.month_in, query_ch.mday_in,
                                          query_ch.count_in}));
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** gregorian_day_number_converter: FAILED **");
      $finish;
    end
  end

  // tests

  task automatic test_directed_dates();
    send_query(date_query(0, 1, 1));
    send_query(date_query(0, 2, 29));
    send_query(date_query(0, 3, 1));
    send_query(date_query(0, 1, 0));
    send_query(date_query(0, 12, 31));
    send_query(date_query(100, 2, 28));
    send_query(date_query(100, 3, 1));
    send_query(date_query(400, 2, 29));
    send_query(date_query(YEAR_MAX, 12, 31));
    send_query(date_query(16383, 15, 31));
    send_query(date_query(5000, 0, 15));
    send_query(date_query(1234, 13, 5));
    send_query(date_query(77, 14, 31));
    send_query(date_query(24, 2, 31));
  endtask

  task automatic test_directed_counts();
    send_query(count_query(0));
    send_query(count_query(59));
    send_query(count_query(60));
    send_query(count_query(365));
    send_query(count_query(366));
    send_query(count_query(146096));
    send_query(count_query(146097));
    send_query(count_query(COUNT_MAX));
    send_query(count_query(COUNT_MAX + 1));
    send_query(count_query((1 << gdc_pkg::COUNT_W) - 1));
  endtask

  task automatic test_random_mix(input int n);
    for (int i = 0; i < n; i++) begin
      idle_en = ((i / 100) % 3) != 2;
      send_query(random_query());
    end
  endtask

  task automatic test_backpressure();
    idle_en      = 1'b0;
    hold_request = 80;
    for (int i = 0; i < 60; i++) begin
      send_query(random_query());
    end
  endtask

  task automatic test_drain_pause();
    idle_en = 1'b1;
    for (int i = 0; i < 20; i++) begin
      send_query(random_query());
    end
    wait_drained();
    for (int i = 0; i < 20; i++) begin
      send_query(random_query());
    end
  endtask

  task automatic test_full_rate(input int n);
    idle_en = 1'b0;
    for (int i = 0; i < n; i++) begin
      send_query(random_query());
    end
  endtask

  initial begin
    rst                <= 1'b1;
    query_ch.valid     <= 1'b0;
    query_ch.func      <= FUNC_DATE_TO_COUNT;
    query_ch.year_in   <= '0;
    query_ch.month_in  <= '0;
    query_ch.mday_in   <= '0;
    query_ch.count_in  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_dates();
    test_directed_counts();
    test_random_mix(560);
    test_backpressure();
    test_drain_pause();
    test_full_rate(150);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("** gregorian_day_number_converter: PASSED **");
    end else begin
      $display("** gregorian_day_number_converter: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/gdc_pkg.sv
design/gdc_if.sv
design/gdc_year_est.sv
design/gdc_leap.sv
design/gdc_date.sv
design/gregorian_day_number_converter.sv
sim/gregorian_day_number_converter_tb.sv
